@@ src/amsgu_pkg.sv @@
// ----------------------------------------------------------------------------
// AMSGrad update package
// Shared widths, datapath command codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package amsgu_pkg;

    localparam int DataW = 32;
    localparam int IdxW  = 12;
    localparam int LrW   = 24;
    localparam int BetaW = 16;
    localparam int CfgW  = 24;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] REG_LR   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_B1   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_B2   = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_EPS  = 2'd3;

    localparam logic [LrW-1:0]   LR_RST  = 24'd16777;
    localparam logic [BetaW-1:0] B1_RST  = 16'd58982;
    localparam logic [BetaW-1:0] B2_RST  = 16'd65470;
    localparam logic [BetaW-1:0] EPS_RST = 16'd43;

    // divider quotient bits per operation, and root bits
    localparam logic [6:0] STEPS_MC  = 7'd40;
    localparam logic [6:0] STEPS_VC  = 7'd33;
    localparam logic [6:0] STEPS_DL  = 7'd43;
    localparam logic [5:0] STEPS_SQRT = 6'd36;

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP   = 5'd0;
    localparam op_t OP_CLEAR = 5'd1;
    localparam op_t OP_LOAD  = 5'd2;
    localparam op_t OP_SLOT  = 5'd3;
    localparam op_t OP_PW1   = 5'd4;
    localparam op_t OP_PW2   = 5'd5;
    localparam op_t OP_M1    = 5'd6;
    localparam op_t OP_M2    = 5'd7;
    localparam op_t OP_M3    = 5'd8;
    localparam op_t OP_G2    = 5'd9;
    localparam op_t OP_V1    = 5'd10;
    localparam op_t OP_V2    = 5'd11;
    localparam op_t OP_MC    = 5'd12;
    localparam op_t OP_VC    = 5'd13;
    localparam op_t OP_SQ    = 5'd14;
    localparam op_t OP_L1    = 5'd15;
    localparam op_t OP_L2    = 5'd16;
    localparam op_t OP_L3    = 5'd17;
    localparam op_t OP_DL    = 5'd18;
    localparam op_t OP_OUT   = 5'd19;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage

@@ src/amsgu_item_if.sv @@
// ----------------------------------------------------------------------------
// AMSGrad item channel
// Valid/ready channel carrying one weight element request.
// ----------------------------------------------------------------------------
interface amsgu_item_if
    import amsgu_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] weight_in;
    logic signed [DataW-1:0] gradient;
    logic [IdxW-1:0]         element_index;
    logic                    pass_start;

    modport source (output valid, output weight_in, output gradient,
                    output element_index, output pass_start, input ready);
    modport sink   (input valid, input weight_in, input gradient,
                    input element_index, input pass_start, output ready);
endinterface

@@ src/amsgu_result_if.sv @@
// ----------------------------------------------------------------------------
// AMSGrad result channel
// Valid/ready channel carrying one updated weight element.
// ----------------------------------------------------------------------------
interface amsgu_result_if
    import amsgu_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] weight_out;
    logic [IdxW-1:0]         index_out;

    modport source (output valid, output weight_out, output index_out, input ready);
    modport sink   (input valid, input weight_out, input index_out, output ready);
endinterface

@@ src/amsgrad_weight_update.sv @@
// ----------------------------------------------------------------------------
// AMSGrad weight update
// Bias-corrected AMSGrad step for one weight element per request.
// ----------------------------------------------------------------------------
// Requests enter on the item channel (weight, gradient, element index, pass
// start mark); one updated weight per request leaves on the result channel.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// the block is idle: 0 learning rate, 1 beta1, 2 beta2, 3 epsilon.
// After reset the block sweeps the three moment stores to zero, one entry per
// cycle, and takes no request until the sweep ends.
// One request is processed at a time, and the next is taken only after the
// last one has gone to the output register: divisions of 40, 33 and 43 quotient
// bits and a 36-step root, all one bit per cycle on a shared divider and a root
// unit, plus index reduction, multiply and memory steps.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following result holds inside the block
// until the output register frees up.
// ----------------------------------------------------------------------------
module amsgrad_weight_update
    import amsgu_pkg::*;
#(
    parameter int ELEMENTS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    amsgu_item_if.sink          item,
    amsgu_result_if.source      result,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic ready;

    amsgu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    assign item.ready = ready;

    amsgu_dp #(
        .ELEMENTS (ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .weight_in     (item.weight_in),
        .gradient      (item.gradient),
        .element_index (item.element_index),
        .pass_start    (item.pass_start),
        .res_ready     (result.ready),
        .res_valid     (result.valid),
        .weight_out    (result.weight_out),
        .index_out     (result.index_out)
    );

endmodule

@@ src/amsgu_div.sv @@
// ----------------------------------------------------------------------------
// AMSGrad divider
// Restoring divider, one quotient bit per cycle, preloaded partial remainder.
// ----------------------------------------------------------------------------
module amsgu_div
    import amsgu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [71:0] num,
    input  logic [39:0] rem_init,
    input  logic [39:0] den,
    input  logic [6:0]  steps,
    output logic        busy,
    output logic [43:0] quot
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [39:0] rem_reg;
    logic [39:0] den_reg;
    logic [71:0] sh_reg;
    logic [43:0] quot_reg;
    logic [40:0] trial;
    logic [40:0] diff;
    logic        ge;

    assign trial = {rem_reg, sh_reg[71]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != 7'd1;
            cnt_reg  <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            den_reg  <= den;
            sh_reg   <= num;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[39:0] : trial[39:0];
            sh_reg   <= {sh_reg[70:0], 1'b0};
            quot_reg <= {quot_reg[42:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

@@ src/amsgu_sqrt.sv @@
// ----------------------------------------------------------------------------
// AMSGrad square root
// Digit-by-digit root of a Q8.24 value, one root bit per cycle, Q.32 result.
// ----------------------------------------------------------------------------
module amsgu_sqrt
    import amsgu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        busy,
    output logic [35:0] root
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] x_reg;
    logic [39:0] rem_reg;
    logic [35:0] root_reg;
    logic [39:0] rem_sh;
    logic [39:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[37:0], x_reg[31:30]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEPS_SQRT;
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != 6'd1;
            cnt_reg  <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[29:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[34:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

@@ src/amsgu_dp.sv @@
// ----------------------------------------------------------------------------
// AMSGrad datapath
// Config registers, moment stores, shared multiplier, divider, root, output.
// ----------------------------------------------------------------------------
module amsgu_dp
    import amsgu_pkg::*;
#(
    parameter int ELEMENTS = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic                    cfg_we,
    input  logic [CfgIdxW-1:0]      cfg_index,
    input  logic [CfgW-1:0]         cfg_data,
    input  logic signed [DataW-1:0] weight_in,
    input  logic signed [DataW-1:0] gradient,
    input  logic [IdxW-1:0]         element_index,
    input  logic                    pass_start,
    input  logic                    res_ready,
    output logic                    res_valid,
    output logic signed [DataW-1:0] weight_out,
    output logic [IdxW-1:0]         index_out
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam logic [24:0] Recip = 25'(((1 << 24) + ELEMENTS - 1) / ELEMENTS);
    localparam logic [31:0] ElemW = 32'(ELEMENTS);

    logic [LrW-1:0]   lr_reg;
    logic [BetaW-1:0] b1_reg;
    logic [BetaW-1:0] b2_reg;
    logic [BetaW-1:0] eps_reg;
    logic [31:0]      p1_reg;
    logic [31:0]      p2_reg;

    logic signed [31:0] w_reg;
    logic signed [31:0] g_reg;
    logic [IdxW-1:0]    idx_reg;
    logic               ps_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      clr_reg;
    logic [11:0]        q_reg;

    logic [31:0] mem_m [ELEMENTS];
    logic [31:0] mem_v [ELEMENTS];
    logic [31:0] mem_vh [ELEMENTS];
    logic [31:0] m_rd_reg;
    logic [31:0] v_rd_reg;
    logic [31:0] vh_rd_reg;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod_reg;
    logic signed [67:0] acc_reg;

    logic signed [31:0] m_reg;
    logic [30:0]        g2_reg;
    logic [31:0]        vh_reg;
    logic [37:0]        mc_reg;
    logic [36:0]        d_reg;
    logic [62:0]        num0_reg;
    logic               sat_reg;

    logic               res_valid_reg;
    logic signed [31:0] wout_reg;
    logic [IdxW-1:0]    iout_reg;

    logic [31:0]        magg;
    logic [31:0]        magm;
    logic [16:0]        omb1;
    logic [16:0]        omb2;
    logic [32:0]        c1;
    logic [32:0]        c2;
    logic signed [67:0] m_sum;
    logic signed [67:0] m_shift;
    logic signed [31:0] m_next;
    logic [67:0]        v_sum;
    logic [31:0]        v_next;
    logic [31:0]        vh_next;
    logic [67:0]        p_rnd;
    logic [67:0]        g2_rnd;
    logic [63:0]        mc_num;
    logic [63:0]        vc_num;
    logic [70:0]        dl_num;
    logic               dl_sat;
    logic [37:0]        mc_next;
    logic [31:0]        vc_next;
    logic [36:0]        d_sum;
    logic [67:0]        num0_sum;
    logic [42:0]        delta;
    logic signed [44:0] res_full;
    logic signed [31:0] res_next;
    logic [36:0]        q_prod;
    logic [31:0]        slot_full;

    logic        div_start;
    logic [71:0] div_num;
    logic [39:0] div_rem_init;
    logic [39:0] div_den;
    logic [6:0]  div_steps;
    logic        div_busy;
    logic [43:0] div_quot;
    logic        sqrt_busy;
    logic [35:0] sqrt_root;
    logic        mem_we;
    logic [AW-1:0] mem_wa;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RST;
            b1_reg  <= B1_RST;
            b2_reg  <= B2_RST;
            eps_reg <= EPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LR:  lr_reg  <= cfg_data;
                REG_B1:  b1_reg  <= cfg_data[BetaW-1:0];
                REG_B2:  b2_reg  <= cfg_data[BetaW-1:0];
                REG_EPS: eps_reg <= cfg_data[BetaW-1:0];
                default: ;
            endcase
        end
    end

    assign magg = g_reg[31] ? 32'(-g_reg) : 32'(g_reg);
    assign magm = m_reg[31] ? 32'(-m_reg) : 32'(m_reg);
    assign omb1 = 17'h10000 - {1'b0, b1_reg};
    assign omb2 = 17'h10000 - {1'b0, b2_reg};
    assign c1   = 33'h1_0000_0000 - {1'b0, p1_reg};
    assign c2   = 33'h1_0000_0000 - {1'b0, p2_reg};

    // index reduction by reciprocal multiply
    assign q_prod    = {25'd0, element_index} * {12'd0, Recip};
    assign slot_full = {20'd0, idx_reg} - ({20'd0, q_reg} * ElemW);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_PW1:
            begin
                mul_a = {2'b00, p1_reg};
                mul_b = {18'd0, b1_reg};
            end
            OP_PW2:
            begin
                mul_a = {2'b00, p2_reg};
                mul_b = {18'd0, b2_reg};
            end
            OP_M1:
            begin
                mul_a = {{2{m_rd_reg[31]}}, m_rd_reg};
                mul_b = {18'd0, b1_reg};
            end
            OP_M2:
            begin
                mul_a = {{2{g_reg[31]}}, g_reg};
                mul_b = {17'd0, omb1};
            end
            OP_M3:
            begin
                mul_a = {2'b00, magg};
                mul_b = {2'b00, magg};
            end
            OP_G2:
            begin
                mul_a = {2'b00, v_rd_reg};
                mul_b = {18'd0, b2_reg};
            end
            OP_V1:
            begin
                mul_a = {3'b000, g2_reg};
                mul_b = {17'd0, omb2};
            end
            OP_L1:
            begin
                mul_a = {10'd0, lr_reg};
                mul_b = {15'd0, mc_reg[18:0]};
            end
            OP_L2:
            begin
                mul_a = {10'd0, lr_reg};
                mul_b = {15'd0, mc_reg[37:19]};
            end
            default: ;
        endcase
    end

    assign p_rnd   = prod_reg + 68'sd32768;
    assign g2_rnd  = prod_reg + 68'sd2147483648;
    assign m_sum   = acc_reg + prod_reg + 68'sd32768;
    assign m_shift = m_sum >>> 16;
    assign m_next  = (m_shift > 68'sd2147483647) ? 32'sh7FFF_FFFF :
                     (m_shift < -68'sd2147483648) ? 32'sh8000_0000 : m_shift[31:0];
    assign v_sum   = acc_reg + prod_reg + 68'sd32768;
    assign v_next  = (|v_sum[67:48]) ? 32'hFFFF_FFFF : v_sum[47:16];
    assign vh_next = (v_next > vh_rd_reg) ? v_next : vh_rd_reg;

    assign mc_num  = {magm, 32'd0} + {32'd0, c1[32:1]};
    assign vc_num  = {vh_reg, 32'd0} + {32'd0, c2[32:1]};
    assign dl_num  = {num0_reg, 8'd0} + {35'd0, d_reg[36:1]};
    assign dl_sat  = {8'd0, num0_reg} >= {d_reg, 34'd0};
    assign mc_next = (sat_reg || (|div_quot[39:38])) ? 38'h3F_FFFF_FFFF : div_quot[37:0];
    assign vc_next = (sat_reg || div_quot[32]) ? 32'hFFFF_FFFF : div_quot[31:0];
    assign d_sum   = {1'b0, sqrt_root} + {21'd0, eps_reg};
    assign num0_sum = acc_reg + (prod_reg <<< 19);
    assign delta   = sat_reg ? 43'h400_0000_0000 : div_quot[42:0];
    assign res_full = m_reg[31] ? ({{13{w_reg[31]}}, w_reg} + $signed({2'b00, delta})) :
                                  ({{13{w_reg[31]}}, w_reg} - $signed({2'b00, delta}));
    assign res_next = (res_full > 45'sd2147483647) ? 32'sh7FFF_FFFF :
                      (res_full < -45'sd2147483648) ? 32'sh8000_0000 : res_full[31:0];

    // divider command
    always_comb
    begin
        div_start    = 1'b0;
        div_num      = '0;
        div_rem_init = '0;
        div_den      = '0;
        div_steps    = STEPS_MC;
        case (cmd.op)
            OP_MC:
            begin
                div_start    = 1'b1;
                div_num      = {mc_num[39:0], 32'd0};
                div_rem_init = {16'd0, mc_num[63:40]};
                div_den      = {7'd0, c1};
                div_steps    = STEPS_MC;
            end
            OP_VC:
            begin
                div_start    = 1'b1;
                div_num      = {vc_num[32:0], 39'd0};
                div_rem_init = {9'd0, vc_num[63:33]};
                div_den      = {7'd0, c2};
                div_steps    = STEPS_VC;
            end
            OP_DL:
            begin
                div_start    = 1'b1;
                div_num      = {dl_num[42:0], 29'd0};
                div_rem_init = {12'd0, dl_num[70:43]};
                div_den      = {3'd0, d_reg};
                div_steps    = STEPS_DL;
            end
            default: ;
        endcase
    end

    amsgu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .rem_init (div_rem_init),
        .den      (div_den),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    amsgu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQ),
        .radicand (vc_next),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // running powers and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= 32'hFFFF_FFFF;
            p2_reg  <= 32'hFFFF_FFFF;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.op == OP_PW2 && ps_reg)
                p1_reg <= p_rnd[47:16];
            if (cmd.op == OP_M1 && ps_reg)
                p2_reg <= p_rnd[47:16];
            if (cmd.op == OP_CLEAR)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    // moment stores
    assign mem_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_V2);
    assign mem_wa = (cmd.op == OP_CLEAR) ? clr_reg : slot_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_m[mem_wa]  <= (cmd.op == OP_CLEAR) ? 32'd0 : 32'(m_reg);
            mem_v[mem_wa]  <= (cmd.op == OP_CLEAR) ? 32'd0 : v_next;
            mem_vh[mem_wa] <= (cmd.op == OP_CLEAR) ? 32'd0 : vh_next;
        end
        m_rd_reg  <= mem_m[slot_reg];
        v_rd_reg  <= mem_v[slot_reg];
        vh_rd_reg <= mem_vh[slot_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                w_reg   <= weight_in;
                g_reg   <= gradient;
                idx_reg <= element_index;
                ps_reg  <= pass_start;
                q_reg   <= q_prod[35:24];
            end
            OP_SLOT: slot_reg <= slot_full[AW-1:0];
            OP_M2:   acc_reg  <= prod_reg;
            OP_M3:   m_reg    <= m_next;
            OP_G2:   g2_reg   <= g2_rnd[62:32];
            OP_V1:   acc_reg  <= prod_reg;
            OP_V2:   vh_reg   <= vh_next;
            OP_MC:   sat_reg  <= {16'd0, mc_num[63:40]} >= {7'd0, c1};
            OP_VC:
            begin
                mc_reg  <= mc_next;
                sat_reg <= {9'd0, vc_num[63:33]} >= {7'd0, c2};
            end
            OP_L1:   d_reg    <= (d_sum == 37'd0) ? 37'd1 : d_sum;
            OP_L2:   acc_reg  <= prod_reg;
            OP_L3:   num0_reg <= num0_sum[62:0];
            OP_DL:   sat_reg  <= dl_sat;
            OP_OUT:
            begin
                wout_reg <= res_next;
                iout_reg <= idx_reg;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign res_valid  = res_valid_reg;
    assign weight_out = wout_reg;
    assign index_out  = iout_reg;

    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.out_free  = !res_valid_reg || res_ready;
    assign sts.clr_last  = clr_reg == AW'(ELEMENTS - 1);

endmodule

@@ src/amsgu_ctrl.sv @@
// ----------------------------------------------------------------------------
// AMSGrad controller
// Sequences the clear sweep and the per-element datapath steps.
// ----------------------------------------------------------------------------
module amsgu_ctrl
    import amsgu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MODW  = 5'd2;
    localparam logic [4:0] S_SLOT  = 5'd3;
    localparam logic [4:0] S_PW1   = 5'd4;
    localparam logic [4:0] S_PW2   = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_G2    = 5'd9;
    localparam logic [4:0] S_V1    = 5'd10;
    localparam logic [4:0] S_V2    = 5'd11;
    localparam logic [4:0] S_MC    = 5'd12;
    localparam logic [4:0] S_MCW   = 5'd13;
    localparam logic [4:0] S_VC    = 5'd14;
    localparam logic [4:0] S_VCW   = 5'd15;
    localparam logic [4:0] S_SQ    = 5'd16;
    localparam logic [4:0] S_SQW   = 5'd17;
    localparam logic [4:0] S_L1    = 5'd18;
    localparam logic [4:0] S_L2    = 5'd19;
    localparam logic [4:0] S_L3    = 5'd20;
    localparam logic [4:0] S_DL    = 5'd21;
    localparam logic [4:0] S_DLW   = 5'd22;
    localparam logic [4:0] S_OUT   = 5'd23;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       accept;

    assign item_ready = state_reg == S_IDLE;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MODW;
                end
            end
            S_MODW:  if (!sts.div_busy) state_next = S_SLOT;
            S_SLOT:  begin cmd.op = OP_SLOT; state_next = S_PW1; end
            S_PW1:   begin cmd.op = OP_PW1;  state_next = S_PW2; end
            S_PW2:   begin cmd.op = OP_PW2;  state_next = S_M1;  end
            S_M1:    begin cmd.op = OP_M1;   state_next = S_M2;  end
            S_M2:    begin cmd.op = OP_M2;   state_next = S_M3;  end
            S_M3:    begin cmd.op = OP_M3;   state_next = S_G2;  end
            S_G2:    begin cmd.op = OP_G2;   state_next = S_V1;  end
            S_V1:    begin cmd.op = OP_V1;   state_next = S_V2;  end
            S_V2:    begin cmd.op = OP_V2;   state_next = S_MC;  end
            S_MC:    begin cmd.op = OP_MC;   state_next = S_MCW; end
            S_MCW:   if (!sts.div_busy) state_next = S_VC;
            S_VC:    begin cmd.op = OP_VC;   state_next = S_VCW; end
            S_VCW:   if (!sts.div_busy) state_next = S_SQ;
            S_SQ:    begin cmd.op = OP_SQ;   state_next = S_SQW; end
            S_SQW:   if (!sts.sqrt_busy) state_next = S_L1;
            S_L1:    begin cmd.op = OP_L1;   state_next = S_L2;  end
            S_L2:    begin cmd.op = OP_L2;   state_next = S_L3;  end
            S_L3:    begin cmd.op = OP_L3;   state_next = S_DL;  end
            S_DL:    begin cmd.op = OP_DL;   state_next = S_DLW; end
            S_DLW:   if (!sts.div_busy) state_next = S_OUT;
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MODW))
        else $error("request not loaded after accept");

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!sts.div_busy && !sts.sqrt_busy))
        else $error("arithmetic unit busy while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !sts.out_free) |=> state_reg == S_OUT)
        else $error("result dropped while output register full");

endmodule
